@@ rtl/core/assert_macros.svh @@
// Assertion macros for the matcher RTL; asm_match_core uses them.
// Modules that use them provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/asm_pkg.sv @@
// Package for the anchored subsequence matcher: widths, register indexes,
// default parameter values and the character fold function. No dependencies.
`default_nettype none

package asm_pkg;

  localparam int unsigned CHAR_W              = 8;
  localparam int unsigned CFG_IDX_W           = 2;
  localparam int unsigned CFG_DATA_W          = 64;
  localparam int unsigned PLEN_REG_W          = 4;
  localparam int unsigned MAXLEN_REG_W        = 10;
  localparam int unsigned MAX_PATTERN_DEF     = 8;
  localparam int unsigned MAX_WORD_LENGTH_DEF = 1023;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd2;

  localparam logic [CHAR_W-1:0] LOWER_A   = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_DIFF = 8'h20;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    if (c >= LOWER_A && c <= LOWER_Z) begin
      return c - CASE_DIFF;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/asm_cfg_regs.sv @@
// Configuration registers of the matcher: folded pattern, clamped pattern
// length and length limit. Depends on asm_pkg.
`default_nettype none

module asm_cfg_regs
  import asm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF,
  localparam int unsigned CNT_W      = $clog2(MAX_PATTERN + 1),
  localparam int unsigned PAT_W      = MAX_PATTERN * CHAR_W
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  output logic      [PAT_W-1:0]        pattern_o,
  output logic      [CNT_W-1:0]        plen_o,
  output logic      [MAXLEN_REG_W-1:0] max_len_o
);

  logic [PAT_W-1:0]        pattern_q, pattern_d;
  logic [PLEN_REG_W-1:0]   plen_q, plen_d;
  logic [MAXLEN_REG_W-1:0] max_len_q, max_len_d;
  logic                    wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_comb begin
    pattern_d = pattern_q;
    plen_d    = plen_q;
    max_len_d = max_len_q;
    if (wr) begin
      unique case (cfg_index_i)
        CFG_PATTERN_CHARS: begin
          for (int k = 0; k < MAX_PATTERN; k++) begin
            pattern_d[k*CHAR_W +: CHAR_W] = fold_char(cfg_data_i[k*CHAR_W +: CHAR_W]);
          end
        end
        CFG_PATTERN_LEN: plen_d    = cfg_data_i[PLEN_REG_W-1:0];
        CFG_MAX_LENGTH:  max_len_d = cfg_data_i[MAXLEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      plen_q    <= '0;
      max_len_q <= '0;
    end else begin
      pattern_q <= pattern_d;
      plen_q    <= plen_d;
      max_len_q <= max_len_d;
    end
  end

  assign pattern_o = pattern_q;
  assign plen_o    = (plen_q > PLEN_REG_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN)
                                                         : CNT_W'(plen_q);
  assign max_len_o = max_len_q;

endmodule

`default_nettype wire

@@ rtl/core/asm_match_core.sv @@
// Per-word match state and the one-character update with the end-of-word
// verdict. Depends on asm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module asm_match_core
  import asm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN     = MAX_PATTERN_DEF,
  parameter int unsigned MAX_WORD_LENGTH = MAX_WORD_LENGTH_DEF,
  localparam int unsigned CNT_W          = $clog2(MAX_PATTERN + 1),
  localparam int unsigned PAT_W          = MAX_PATTERN * CHAR_W,
  localparam int unsigned LEN_W          = $clog2(MAX_WORD_LENGTH + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    step_i,
  input  wire logic [CHAR_W-1:0]       ch_i,
  input  wire logic                    last_i,
  input  wire logic [PAT_W-1:0]        pattern_i,
  input  wire logic [CNT_W-1:0]        plen_i,
  input  wire logic [MAXLEN_REG_W-1:0] max_len_i,
  output logic                         res_match_o,
  output logic      [LEN_W-1:0]        res_len_o
);

  localparam int unsigned CMP_W = (LEN_W > MAXLEN_REG_W) ? LEN_W : MAXLEN_REG_W;

  logic [CNT_W-1:0]  matched_q, matched_d, matched_nx;
  logic [LEN_W-1:0]  len_q, len_d, len_nx;
  logic              anchor_fail_q, anchor_fail_d, anchor_fail_nx;
  logic [CHAR_W-1:0] c;
  logic [CHAR_W-1:0] pat_cur;
  logic [CMP_W-1:0]  len_cmp;

  assign c = fold_char(ch_i);

  always_comb begin
    pat_cur = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (matched_q == CNT_W'(k)) begin
        pat_cur = pattern_i[k*CHAR_W +: CHAR_W];
      end
    end
  end

  always_comb begin
    matched_nx     = matched_q;
    anchor_fail_nx = anchor_fail_q;
    if (len_q == '0) begin
      if (plen_i != '0) begin
        if (c == pattern_i[CHAR_W-1:0]) begin
          matched_nx = CNT_W'(1);
        end else begin
          anchor_fail_nx = 1'b1;
        end
      end
    end else if (!anchor_fail_q && matched_q != '0 && matched_q < plen_i &&
                 c == pat_cur) begin
      matched_nx = matched_q + CNT_W'(1);
    end
    len_nx = (len_q != LEN_W'(MAX_WORD_LENGTH)) ? len_q + LEN_W'(1) : len_q;
  end

  assign len_cmp     = CMP_W'(len_nx);
  assign res_match_o = !anchor_fail_nx && matched_nx >= plen_i &&
                       len_cmp >= CMP_W'(plen_i) &&
                       (max_len_i == '0 || len_cmp <= CMP_W'(max_len_i));
  assign res_len_o   = len_nx;

  always_comb begin
    matched_d     = matched_q;
    len_d         = len_q;
    anchor_fail_d = anchor_fail_q;
    if (step_i) begin
      if (last_i) begin
        matched_d     = '0;
        len_d         = '0;
        anchor_fail_d = 1'b0;
      end else begin
        matched_d     = matched_nx;
        len_d         = len_nx;
        anchor_fail_d = anchor_fail_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q     <= '0;
      len_q         <= '0;
      anchor_fail_q <= 1'b0;
    end else begin
      matched_q     <= matched_d;
      len_q         <= len_d;
      anchor_fail_q <= anchor_fail_d;
    end
  end

  `ASM_ASSERT(a_word_end_clears, (step_i && last_i) |=> (len_q == '0 && matched_q == '0 && !anchor_fail_q), "state not cleared after word end")
  `ASM_ASSERT(a_match_needs_len, (matched_q != '0) |-> (len_q != '0), "matched count without characters")
  `ASM_ASSERT(a_fail_no_match, anchor_fail_q |-> (matched_q == '0), "anchor failure with matched characters")

endmodule

`default_nettype wire

@@ rtl/core/anchored_subsequence_matcher_top.sv @@
// Anchored subsequence matcher
//
// Channels: s_axis carries one character per transaction (tdata = ch, tlast
// marks the last character of a word). m_axis carries one result per word
// (tdata bit 0 = is_match, then word_length). The cfg channel writes
// register cfg_index_i: 0 pattern_chars, 1 pattern_len, 2 max_length;
// cfg_ready_o is always high and other indexes are ignored.
//
// Path: a character enters the input register, is evaluated as it leaves it,
// and the result of a last character is held in the output register for m_axis.
// Throughput: one character per cycle unless a stalled result holds back a last
// character, set by the single input register feeding the state update.
//
// Reset clears the word state, the configuration and both valid flags.
// When the receiver stalls, the held result blocks the next last character,
// and later input waits behind it; characters before it keep flowing.
//
// Depends on asm_pkg, asm_cfg_regs and asm_match_core.
`default_nettype none

module anchored_subsequence_matcher_top
  import asm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN     = MAX_PATTERN_DEF,
  parameter int unsigned MAX_WORD_LENGTH = MAX_WORD_LENGTH_DEF,
  localparam int unsigned CNT_W          = $clog2(MAX_PATTERN + 1),
  localparam int unsigned PAT_W          = MAX_PATTERN * CHAR_W,
  localparam int unsigned LEN_W          = $clog2(MAX_WORD_LENGTH + 1),
  localparam int unsigned OUT_W          = ((LEN_W + 1 + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [CHAR_W-1:0]     s_axis_tdata,   // [7:0] ch
  input  wire logic                  s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [OUT_W-1:0]      m_axis_tdata,   // [0] is_match, [LEN_W:1] word_length
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [PAT_W-1:0]        pattern;
  logic [CNT_W-1:0]        plen;
  logic [MAXLEN_REG_W-1:0] max_len;

  logic              in_valid_q, in_valid_d;
  logic [CHAR_W-1:0] in_ch_q;
  logic              in_last_q;
  logic              in_adv;
  logic              res_match;
  logic [LEN_W-1:0]  res_len;

  logic              out_valid_q, out_valid_d;
  logic              out_match_q;
  logic [LEN_W-1:0]  out_len_q;

  asm_cfg_regs #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pattern_o   (pattern),
    .plen_o      (plen),
    .max_len_o   (max_len)
  );

  asm_match_core #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_WORD_LENGTH (MAX_WORD_LENGTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_adv),
    .ch_i        (in_ch_q),
    .last_i      (in_last_q),
    .pattern_i   (pattern),
    .plen_i      (plen),
    .max_len_i   (max_len),
    .res_match_o (res_match),
    .res_len_o   (res_len)
  );

  // advance unless a last character would overwrite a stalled result
  assign in_adv        = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || in_adv;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (in_adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_adv && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q   <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (in_adv && in_last_q) begin
      out_match_q <= res_match;
      out_len_q   <= res_len;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_len_q, out_match_q});

endmodule

`default_nettype wire
